// ===== rtl/stepper_axis_mover_defines.svh =====
// Assertion macros shared by the stepper axis mover RTL.
`ifndef STEPPER_AXIS_MOVER_DEFINES_SVH
`define STEPPER_AXIS_MOVER_DEFINES_SVH

// Whenever ante holds on a clock edge, cons must hold on that same edge.
`define SAM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stepper axis mover: implication check failed");

// The condition must never hold on any clock edge.
`define SAM_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("stepper axis mover: forbidden condition seen");

`endif

// ===== rtl/sam_pkg.sv =====
// Shared types and constants of the stepper axis mover.
package sam_pkg;

   localparam int POSITION_BITS_DEF = 32;
   localparam int WAIT_BITS         = 10;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [WAIT_BITS-1:0] WAIT_NUMERATOR = WAIT_BITS'(10 * 100);

   localparam logic DIR_UP   = 1'b0;
   localparam logic DIR_DOWN = 1'b1;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_MOVE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_MOVING  = 3'd1,
      ST_ARRIVED = 3'd2,
      ST_LIMIT   = 3'd3,
      ST_REJECT  = 3'd4
   } status_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] target;
      logic [7:0]         speed;
      logic               min_switch_n;
      logic               max_switch_n;
   } req_type;

   typedef struct packed {
      logic               step_pulse;
      logic               direction;
      logic signed [31:0] position;
      logic               min_hit;
      logic               max_hit;
      logic [2:0]         status;
   } rsp_type;

   // Classified command handed from the front to the back through the queue.
   typedef struct packed {
      logic                 is_move;
      logic                 speed_zero;
      logic [WAIT_BITS-1:0] reload;
      logic                 min_switch_n;
      logic                 max_switch_n;
   } job_type;

endpackage

// ===== rtl/sam_front.sv =====
// Front end: accepts items, classifies them and divides out the step wait.
module sam_front #(
   parameter int POSITION_BITS = sam_pkg::POSITION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sam_pkg::req_type         req_data,
   output logic                     push,
   output sam_pkg::job_type         push_cmd,
   output logic [POSITION_BITS-1:0] push_goal,
   input  logic                     queue_full
);
   import sam_pkg::*;

   localparam int CNT_BITS = $clog2(WAIT_BITS);

   typedef enum logic [2:0] {
      FS_IDLE = 3'b001,
      FS_DIV  = 3'b010,
      FS_PUSH = 3'b100
   } front_state_type;

   front_state_type          state_ff, state_in;
   job_type                  cmd_ff, cmd_in;
   logic [POSITION_BITS-1:0] goal_ff, goal_in;
   logic [7:0]               rem_ff, rem_in;
   logic [WAIT_BITS-1:0]     quo_ff, quo_in;
   logic [7:0]               div_ff, div_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;

   logic       req_accept;
   logic [8:0] trial;
   logic       trial_ge;

   assign req_stall  = (state_ff != FS_IDLE);
   assign req_accept = req_valid && (state_ff == FS_IDLE);
   assign push       = (state_ff == FS_PUSH) && !queue_full;
   assign push_cmd   = cmd_ff;
   assign push_goal  = goal_ff;

   // One restoring division step: bring down the next dividend bit.
   assign trial    = {rem_ff, quo_ff[WAIT_BITS-1]};
   assign trial_ge = (trial >= {1'b0, div_ff});

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      goal_in  = goal_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         FS_IDLE: begin
            if (req_accept) begin
               cmd_in.is_move      = (req_data.kind == KIND_MOVE);
               cmd_in.speed_zero   = (req_data.speed == 8'd0);
               cmd_in.reload       = '0;
               cmd_in.min_switch_n = req_data.min_switch_n;
               cmd_in.max_switch_n = req_data.max_switch_n;
               goal_in             = POSITION_BITS'(req_data.target);
               rem_in              = '0;
               quo_in              = WAIT_NUMERATOR;
               div_in              = req_data.speed;
               cnt_in              = '0;
               if (req_data.kind == KIND_MOVE && req_data.speed != 8'd0) begin
                  state_in = FS_DIV;
               end else begin
                  state_in = FS_PUSH;
               end
            end
         end
         FS_DIV: begin
            rem_in = trial_ge ? 8'(trial - {1'b0, div_ff}) : trial[7:0];
            quo_in = {quo_ff[WAIT_BITS-2:0], trial_ge};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(WAIT_BITS - 1)) begin
               cmd_in.reload = quo_in;
               state_in      = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (!queue_full) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff  <= cmd_in;
      goal_ff <= goal_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== rtl/sam_queue.sv =====
// Short register queue that decouples the front end from the back end.
`include "stepper_axis_mover_defines.svh"

module sam_queue #(
   parameter int WIDTH = sam_pkg::POSITION_BITS_DEF + $bits(sam_pkg::job_type),
   parameter int DEPTH = sam_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SAM_ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `SAM_ASSERT_NEVER(a_no_underflow, clock, reset, pop && !not_empty)
   `SAM_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_BITS'(DEPTH))

endmodule

// ===== rtl/sam_back.sv =====
// Back end: runs the axis state for each command and holds the result register.
`include "stepper_axis_mover_defines.svh"

module sam_back #(
   parameter int POSITION_BITS = sam_pkg::POSITION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  sam_pkg::job_type         cmd,
   input  logic [POSITION_BITS-1:0] cmd_goal,
   output logic                     cmd_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sam_pkg::rsp_type         rsp_data
);
   import sam_pkg::*;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] goal_ff, goal_in;
   logic                     dir_ff, dir_in;
   logic                     moving_ff, moving_in;
   logic [WAIT_BITS-1:0]     reload_ff, reload_in;
   logic [WAIT_BITS-1:0]     wc_ff, wc_in;
   logic                     min_ff, min_in;
   logic                     max_ff, max_in;
   status_type               status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                 step;
   logic                 open_period;
   logic [WAIT_BITS-1:0] wc_dec;

   assign cmd_pop   = cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      pos_in      = pos_ff;
      goal_in     = goal_ff;
      dir_in      = dir_ff;
      moving_in   = moving_ff;
      reload_in   = reload_ff;
      wc_in       = wc_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      status_in   = status_ff;
      step        = 1'b0;
      open_period = 1'b0;
      wc_dec      = wc_ff - WAIT_BITS'(wc_ff != '0);
      if (cmd_pop) begin
         if (cmd.is_move) begin
            if (cmd.speed_zero) begin
               moving_in = 1'b0;
               wc_in     = '0;
               status_in = ST_REJECT;
            end else begin
               goal_in     = cmd_goal;
               reload_in   = cmd.reload;
               dir_in      = ($signed(cmd_goal) > $signed(pos_ff)) ? DIR_UP : DIR_DOWN;
               open_period = 1'b1;
            end
         end else if (moving_ff) begin
            wc_in = wc_dec;
            if (wc_dec == '0) begin
               step        = 1'b1;
               pos_in      = (dir_ff == DIR_UP) ? pos_ff + POSITION_BITS'(1)
                                                : pos_ff - POSITION_BITS'(1);
               open_period = 1'b1;
            end
         end
         // A new step period checks for arrival first, then samples the switches.
         if (open_period) begin
            if (pos_in == goal_in) begin
               moving_in = 1'b0;
               status_in = ST_ARRIVED;
            end else begin
               min_in = min_ff | ~cmd.min_switch_n;
               max_in = max_ff | ~cmd.max_switch_n;
               if ((min_in && dir_in == DIR_DOWN) || (max_in && dir_in == DIR_UP)) begin
                  moving_in = 1'b0;
                  status_in = ST_LIMIT;
               end else begin
                  wc_in     = reload_in;
                  moving_in = 1'b1;
                  status_in = ST_MOVING;
               end
            end
         end
      end

      rsp_data_in            = rsp_data_ff;
      rsp_valid_in           = rsp_valid_ff && rsp_stall;
      if (cmd_pop) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.step_pulse = step;
         rsp_data_in.direction  = dir_in;
         rsp_data_in.position   = 32'(pos_in);
         rsp_data_in.min_hit    = min_in;
         rsp_data_in.max_hit    = max_in;
         rsp_data_in.status     = status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         goal_ff      <= '0;
         dir_ff       <= DIR_UP;
         moving_ff    <= 1'b0;
         reload_ff    <= '0;
         wc_ff        <= '0;
         min_ff       <= 1'b0;
         max_ff       <= 1'b0;
         status_ff    <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         goal_ff      <= goal_in;
         dir_ff       <= dir_in;
         moving_ff    <= moving_in;
         reload_ff    <= reload_in;
         wc_ff        <= wc_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   `SAM_ASSERT_IMPLY(a_moving_has_wait, clock, reset, moving_ff, wc_ff != '0)
   `SAM_ASSERT_IMPLY(a_moving_not_there, clock, reset, moving_ff, pos_ff != goal_ff)
   `SAM_ASSERT_IMPLY(a_step_status, clock, reset, rsp_valid_ff && rsp_data_ff.step_pulse,
      rsp_data_ff.status != ST_IDLE && rsp_data_ff.status != ST_REJECT)

endmodule

// ===== rtl/stepper_axis_mover.sv =====
// Top level of the stepper axis mover: front end, command queue and back end.
//
//   Channel  Ports                           Direction  Contents
//   request  req_valid, req_stall, req_data  in         tick or move item
//   response rsp_valid, rsp_stall, rsp_data  out        one result per item
//
// The front takes no new item until the last one is in the queue; a move with nonzero
// speed holds it while its radix-2 divider forms 1000/speed, one quotient bit a cycle.
// Each popped command is handled by the back end, which writes the result register.
// Reset is synchronous and returns the axis to position zero, idle, latches clear.
// A stalled result stops the back end; the queue then fills and stalls the request side.
module stepper_axis_mover #(
   parameter int POSITION_BITS = sam_pkg::POSITION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sam_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sam_pkg::rsp_type rsp_data
);
   import sam_pkg::*;

   localparam int CMD_BITS   = $bits(job_type);
   localparam int ENTRY_BITS = POSITION_BITS + CMD_BITS;

   logic                     push;
   job_type                  push_cmd;
   logic [POSITION_BITS-1:0] push_goal;
   logic                     queue_full;
   logic                     pop;
   logic [ENTRY_BITS-1:0]    pop_data;
   logic                     queue_valid;
   job_type                  pop_cmd;
   logic [POSITION_BITS-1:0] pop_goal;

   assign pop_cmd  = job_type'(pop_data[CMD_BITS-1:0]);
   assign pop_goal = pop_data[ENTRY_BITS-1:CMD_BITS];

   sam_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_goal  (push_goal),
      .queue_full (queue_full)
   );

   sam_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_goal, push_cmd}),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (queue_valid)
   );

   sam_back #(
      .POSITION_BITS(POSITION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (pop_cmd),
      .cmd_goal  (pop_goal),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
